/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the watchdog RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define DMCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DMCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/dmcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dmcw_pkg;

  localparam int ID_W        = 11;
  localparam int TIMEOUT_W   = 16;
  localparam int DBG_DUTY_W  = 10;
  localparam int DUTY_W      = 11;
  localparam int DATA_W      = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_DATA_W   = 32;
  localparam int IN_USED_W   = 29;
  localparam int OUT_DATA_W  = 24;

  localparam int SILENCE_BITS_DEF = 16;

  localparam logic [ID_W-1:0]       BASE_ID_RST  = 11'd260;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd100;
  localparam logic [DBG_DUTY_W-1:0] DBG_DUTY_RST = 10'd200;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BASE_ID  = 3'd0,
    CFG_TIMEOUT  = 3'd1,
    CFG_DBG_DUTY = 3'd2,
    CFG_DEBUG_A  = 3'd3,
    CFG_DEBUG_B  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]       base_id;
    logic [TIMEOUT_W-1:0]  timeout_ms;
    logic [DBG_DUTY_W-1:0] dbg_duty;
    logic                  debug_a;
    logic                  debug_b;
  } cfg_t;

  // Per-motor controls derived from the item in the input register.
  typedef struct packed {
    logic                     adv;
    logic                     tick;
    logic                     hit;
    logic                     fwd;
    logic                     rev;
    logic                     dbg;
    logic signed [DUTY_W-1:0] cmd_duty;
  } motor_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/dmcw_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module dmcw_cfg import dmcw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DATA_W-1:0]     cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_BASE_ID:  cfg_nxt.base_id    = cfg_wdata[ID_W-1:0];
        CFG_TIMEOUT:  cfg_nxt.timeout_ms = cfg_wdata[TIMEOUT_W-1:0];
        CFG_DBG_DUTY: cfg_nxt.dbg_duty   = cfg_wdata[DBG_DUTY_W-1:0];
        CFG_DEBUG_A:  cfg_nxt.debug_a    = cfg_wdata[0];
        CFG_DEBUG_B:  cfg_nxt.debug_b    = cfg_wdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_id    <= BASE_ID_RST;
      cfg_r.timeout_ms <= TIMEOUT_RST;
      cfg_r.dbg_duty   <= DBG_DUTY_RST;
      cfg_r.debug_a    <= 1'b0;
      cfg_r.debug_b    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hw/rtl/dmcw_motor.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dmcw_motor import dmcw_pkg::*; #(
  parameter int SILENCE_BITS = SILENCE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire motor_ctl_t               ctl,
  input  wire logic [TIMEOUT_W-1:0]     timeout_ms,
  input  wire logic [DBG_DUTY_W-1:0]    dbg_duty,
  output logic signed [DUTY_W-1:0]      duty_nxt
);

  localparam int CMP_W = (SILENCE_BITS > TIMEOUT_W) ? SILENCE_BITS : TIMEOUT_W;

  logic signed [DUTY_W-1:0]  duty_r;
  logic [SILENCE_BITS-1:0]   silence_r;
  logic [SILENCE_BITS-1:0]   silence_nxt;
  logic [SILENCE_BITS-1:0]   silence_inc;
  logic                      timed_out;
  logic signed [DUTY_W-1:0]  test_pos;

  assign test_pos = signed'({1'b0, dbg_duty});

  always_comb begin
    // The counter sticks at all ones, so a timeout at or above that never fires.
    silence_inc = (&silence_r) ? silence_r : silence_r + 1'b1;
    timed_out   = CMP_W'(silence_inc) > CMP_W'(timeout_ms);
    duty_nxt    = duty_r;
    silence_nxt = silence_r;
    if (ctl.tick) begin
      silence_nxt = silence_inc;
      if (timed_out) begin
        duty_nxt = '0;
      end
      // The debug check runs after the timeout, and forward beats reverse.
      if (ctl.dbg && ctl.fwd) begin
        duty_nxt    = test_pos;
        silence_nxt = '0;
      end else if (ctl.dbg && ctl.rev) begin
        duty_nxt    = -test_pos;
        silence_nxt = '0;
      end
    end else if (ctl.hit) begin
      duty_nxt    = ctl.cmd_duty;
      silence_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r    <= '0;
      silence_r <= '0;
    end else if (ctl.adv) begin
      duty_r    <= duty_nxt;
      silence_r <= silence_nxt;
    end
  end

  `DMCW_ASSERT_NEXT(a_hold_idle, !ctl.adv, $stable(duty_r) && $stable(silence_r), "motor state moved without an item")
  `DMCW_ASSERT_NEXT(a_cmd_load, ctl.adv && !ctl.tick && ctl.hit, silence_r == '0 && duty_r == $past(ctl.cmd_duty), "command not applied")
  `DMCW_ASSERT_NEXT(a_dbg_clear, ctl.adv && ctl.tick && ctl.dbg && (ctl.fwd || ctl.rev), silence_r == '0, "debug button did not clear silence")

endmodule

`default_nettype wire

/* hw/rtl/dual_motor_command_watchdog.sv */
`timescale 1ns / 1ps
`default_nettype none

// Dual motor command watchdog.
// Input beats arrive on in_*: in_tuser low means a command frame (identifier and two
// duty bytes in in_tdata), high means a one millisecond tick carrying the debug
// button levels. Every input beat produces exactly one output beat on out_* holding
// both signed motor duties as they stand after that beat.
// A beat is captured in an input register; when it moves on, the motor state and the
// output register are updated together and out_tvalid rises. A stall at the output
// keeps the beat waiting in the input register. One beat per cycle is sustained while
// out_tready stays high; the only limit is the output register, which frees itself in
// the cycle its beat is taken.
// When the receiver holds out_tready low, the output beat holds, the input register
// keeps its beat and in_tready drops only once both are full.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata, one register per cycle;
// the user must write it only while the stream is idle, as the block has no check for it.
// Synchronous reset (rst_n low) clears both duties and silence counters, empties both
// registers and restores base identifier 260, timeout 100, debug duty 200 and debug off.

`include "assert_macros.svh"

module dual_motor_command_watchdog import dmcw_pkg::*; #(
  parameter int SILENCE_BITS = SILENCE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [10:0] frame_id, [18:11] data_low, [26:19] data_high, [27] button_fwd,
  // [28] button_rev, [31:29] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [10:0] duty_a, [21:11] duty_b, [23:22] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DATA_W-1:0]     cfg_wdata
);

  cfg_t                      cfg;
  logic                      in_vld_r;
  logic                      in_vld_nxt;
  logic [IN_USED_W-1:0]      in_data_r;
  logic                      in_mode_r;
  logic                      out_vld_r;
  logic                      out_vld_nxt;
  logic [2*DUTY_W-1:0]       out_data_r;
  logic                      advance;
  logic                      in_fire;
  logic [ID_W-1:0]           frame_id;
  logic [7:0]                data_low;
  logic [7:0]                data_high;
  logic [DBG_DUTY_W-1:0]     cmd_mag;
  logic signed [DUTY_W-1:0]  cmd_duty;
  logic                      hit_a;
  logic                      hit_b;
  motor_ctl_t                ctl_a;
  motor_ctl_t                ctl_b;
  logic signed [DUTY_W-1:0]  duty_a_nxt;
  logic signed [DUTY_W-1:0]  duty_b_nxt;

  dmcw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign frame_id  = in_data_r[10:0];
  assign data_low  = in_data_r[18:11];
  assign data_high = in_data_r[26:19];

  // Magnitude over 32 is just the top ten of the fifteen magnitude bits.
  assign cmd_mag  = {data_high[6:0], data_low[7:5]};
  assign cmd_duty = data_high[7] ? -signed'({1'b0, cmd_mag}) : signed'({1'b0, cmd_mag});

  // Motor B compares one bit wider so a base of all ones never matches.
  assign hit_a = (frame_id == cfg.base_id);
  assign hit_b = ({1'b0, frame_id} == ({1'b0, cfg.base_id} + 12'd1));

  always_comb begin
    ctl_a.adv      = advance;
    ctl_a.tick     = in_mode_r;
    ctl_a.hit      = hit_a;
    ctl_a.fwd      = in_data_r[27];
    ctl_a.rev      = in_data_r[28];
    ctl_a.dbg      = cfg.debug_a;
    ctl_a.cmd_duty = cmd_duty;
    ctl_b          = ctl_a;
    ctl_b.hit      = hit_b && !hit_a;
    ctl_b.dbg      = cfg.debug_b;
  end

  dmcw_motor #(.SILENCE_BITS(SILENCE_BITS)) u_motor_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_a),
    .timeout_ms(cfg.timeout_ms),
    .dbg_duty  (cfg.dbg_duty),
    .duty_nxt  (duty_a_nxt)
  );

  dmcw_motor #(.SILENCE_BITS(SILENCE_BITS)) u_motor_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_b),
    .timeout_ms(cfg.timeout_ms),
    .dbg_duty  (cfg.dbg_duty),
    .duty_nxt  (duty_b_nxt)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_fire) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata[IN_USED_W-1:0];
      in_mode_r <= in_tuser;
    end
    if (advance) begin
      out_data_r <= {duty_b_nxt, duty_a_nxt};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*DUTY_W){1'b0}}, out_data_r};

  `DMCW_ASSERT_NEXT(a_in_kept, in_vld_r && !advance, in_vld_r, "buffered beat dropped")
  `DMCW_ASSERT_NEXT(a_out_loaded, advance, out_vld_r, "processed beat produced no result")
  `DMCW_ASSERT(a_no_overrun, !(in_vld_r && in_fire && !advance), "input register overwritten")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dmcw_pkg::*;

  localparam int SIL_W = SILENCE_BITS_DEF;

  typedef struct {
    logic                   mode;
    logic [ID_W-1:0]        frame_id;
    logic [7:0]             data_low;
    logic [7:0]             data_high;
    logic                   fwd;
    logic                   rev;
  } motor_beat_t;

  typedef struct {
    logic signed [DUTY_W-1:0] duty_a;
    logic signed [DUTY_W-1:0] duty_b;
  } duty_pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [10:0] frame_id, [18:11] data_low, [26:19] data_high, [27] button_fwd,
  // [28] button_rev, [31:29] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [0] mode
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [10:0] duty_a, [21:11] duty_b, [23:22] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_BASE_ID;
  logic [DATA_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the block's registers and motor state.
  logic [ID_W-1:0]          m_base;
  logic [TIMEOUT_W-1:0]     m_timeout;
  logic [DBG_DUTY_W-1:0]    m_test;
  logic                     m_dbg_a;
  logic                     m_dbg_b;
  logic signed [DUTY_W-1:0] m_duty_a;
  logic signed [DUTY_W-1:0] m_duty_b;
  logic [SIL_W-1:0]         m_sil_a;
  logic [SIL_W-1:0]         m_sil_b;

  duty_pair_t pending_duties[$];
  duty_pair_t want_duty;
  int         mismatch_count = 0;
  bit         no_gaps = 1'b0;
  int         hold_req = 0;
  int         sink_hold = 0;
  int         sink_gap = 0;

  dual_motor_command_watchdog DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [DUTY_W-1:0] decode_duty(input logic [7:0] lo,
                                                           input logic [7:0] hi);
    logic signed [DUTY_W-1:0] mag;
    mag = $signed({1'b0, hi[6:0], lo[7:5]});
    return hi[7] ? -mag : mag;
  endfunction

  function automatic void tick_motor(input logic signed [DUTY_W-1:0] d_in,
                                     input logic [SIL_W-1:0] s_in,
                                     input logic dbg, input logic fwd, input logic rev,
                                     output logic signed [DUTY_W-1:0] d_out,
                                     output logic [SIL_W-1:0] s_out);
    d_out = d_in;
    s_out = s_in;
    if (s_out != {SIL_W{1'b1}}) s_out = s_out + 1'b1;
    if (s_out > m_timeout) d_out = '0;
    // Forward wins when both buttons are held.
    if (dbg && fwd) begin
      d_out = $signed({1'b0, m_test});
      s_out = '0;
    end else if (dbg && rev) begin
      d_out = -$signed({1'b0, m_test});
      s_out = '0;
    end
  endfunction

  function automatic void step_watchdog(input motor_beat_t b);
    if (!b.mode) begin
      if (b.frame_id == m_base) begin
        m_duty_a = decode_duty(b.data_low, b.data_high);
        m_sil_a  = '0;
      end else if ({1'b0, b.frame_id} == {1'b0, m_base} + 12'd1) begin
        // The sum is one bit wider so that the top base never matches identifier zero.
        m_duty_b = decode_duty(b.data_low, b.data_high);
        m_sil_b  = '0;
      end
    end else begin
      tick_motor(m_duty_a, m_sil_a, m_dbg_a, b.fwd, b.rev, m_duty_a, m_sil_a);
      tick_motor(m_duty_b, m_sil_b, m_dbg_b, b.fwd, b.rev, m_duty_b, m_sil_b);
    end
  endfunction

  function automatic motor_beat_t frame_beat(input logic [ID_W-1:0] id,
                                             input logic [7:0] lo, input logic [7:0] hi);
    motor_beat_t b;
    b.mode      = 1'b0;
    b.frame_id  = id;
    b.data_low  = lo;
    b.data_high = hi;
    b.fwd       = $urandom_range(0, 1);
    b.rev       = $urandom_range(0, 1);
    return b;
  endfunction

  function automatic motor_beat_t tick_beat(input logic fwd, input logic rev);
    motor_beat_t b;
    b.mode      = 1'b1;
    b.frame_id  = $urandom_range(0, 2047);
    b.data_low  = $urandom_range(0, 255);
    b.data_high = $urandom_range(0, 255);
    b.fwd       = fwd;
    b.rev       = rev;
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Must be entered at a rising edge; leaves tvalid high so that back-to-back
  // beats follow without a gap.
  task automatic push_beat(input motor_beat_t b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.mode;
    in_tdata  <= {3'b000, b.rev, b.fwd, b.data_high, b.data_low, b.frame_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_watchdog(b);
    pending_duties.push_back('{m_duty_a, m_duty_b});
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BASE_ID:  m_base    = value[ID_W-1:0];
      CFG_TIMEOUT:  m_timeout = value[TIMEOUT_W-1:0];
      CFG_DBG_DUTY: m_test    = value[DBG_DUTY_W-1:0];
      CFG_DEBUG_A:  m_dbg_a   = value[0];
      CFG_DEBUG_B:  m_dbg_b   = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned base, input int unsigned timeout,
                                input int unsigned tduty, input bit dbg_a, input bit dbg_b);
    wait_idle();
    write_reg(CFG_BASE_ID, base);
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_DBG_DUTY, tduty);
    write_reg(CFG_DEBUG_A, dbg_a);
    write_reg(CFG_DEBUG_B, dbg_b);
  endtask

  // Runs on the reset register values: debug off, so held buttons do nothing.
  task automatic test_reset_values();
    push_beat(frame_beat(11'd260, 8'h40, 8'h03));
    push_beat(frame_beat(11'd261, 8'hA0, 8'h85));
    push_beat(frame_beat(11'd259, 8'hFF, 8'h7F));
    push_beat(tick_beat(1'b1, 1'b0));
  endtask

  task automatic test_cmd_decode();
    apply_settings(100, 500, 200, 1'b0, 1'b0);
    push_beat(frame_beat(11'd100, 8'hFF, 8'h7F));
    push_beat(frame_beat(11'd101, 8'hFF, 8'hFF));
    // Sign set with a magnitude below 32 must give plain zero.
    push_beat(frame_beat(11'd100, 8'h1F, 8'h80));
    push_beat(frame_beat(11'd101, 8'h20, 8'h00));
    push_beat(frame_beat(11'd100, 8'h00, 8'h00));
    push_beat(frame_beat(11'd101, 8'h3F, 8'h80));
  endtask

  task automatic test_timeout();
    apply_settings(1000, 2, 200, 1'b0, 1'b0);
    push_beat(frame_beat(11'd1000, 8'hFF, 8'h7F));
    push_beat(frame_beat(11'd1001, 8'hFF, 8'hFF));
    repeat (3) push_beat(tick_beat(1'b0, 1'b0));
    apply_settings(1000, 0, 200, 1'b0, 1'b0);
    push_beat(frame_beat(11'd1000, 8'h00, 8'h40));
    push_beat(tick_beat(1'b0, 1'b0));
  endtask

  task automatic test_debug_buttons();
    apply_settings(7, 3, 1023, 1'b1, 1'b0);
    push_beat(frame_beat(11'd8, 8'h80, 8'h3E));
    push_beat(tick_beat(1'b1, 1'b0));
    push_beat(tick_beat(1'b0, 1'b1));
    push_beat(tick_beat(1'b1, 1'b1));
    // After release the debug duty holds until the timeout runs out.
    repeat (4) push_beat(tick_beat(1'b0, 1'b0));
  endtask

  task automatic test_top_base_id();
    apply_settings(2047, 100, 0, 1'b0, 1'b1);
    push_beat(frame_beat(11'd2047, 8'h55, 8'h2A));
    push_beat(frame_beat(11'd0, 8'hFF, 8'hFF));
    push_beat(frame_beat(11'd2046, 8'hFF, 8'h7F));
    push_beat(tick_beat(1'b1, 1'b0));
  endtask

  task automatic test_backpressure();
    apply_settings(300, 40, 512, 1'b1, 1'b1);
    no_gaps  = 1'b1;
    hold_req = 60;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2)
        push_beat(tick_beat($urandom_range(0, 1), $urandom_range(0, 1)));
      else
        push_beat(frame_beat(11'(300 + (i % 2)), $urandom_range(0, 255),
                             $urandom_range(0, 255)));
    end
    wait_idle();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned base;
    int unsigned timeout;
    int unsigned tduty;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] id_b;
    int roll;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0:       base = 0;
        1:       base = 2046;
        2:       base = 2047;
        default: base = $urandom_range(0, 2047);
      endcase
      case ($urandom_range(0, 5))
        0:       timeout = $urandom_range(0, 65535);
        1:       timeout = 0;
        default: timeout = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 3))
        0:       tduty = 0;
        1:       tduty = 1023;
        default: tduty = $urandom_range(0, 1023);
      endcase
      apply_settings(base, timeout, tduty, $urandom_range(0, 1), $urandom_range(0, 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      id_b = m_base + 1'b1;
      for (int n = 0; n < 72; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          roll = $urandom_range(0, 99);
          id = (roll < 40) ? m_base : (roll < 80) ? id_b : 11'($urandom_range(0, 2047));
          push_beat(frame_beat(id, $urandom_range(0, 255), $urandom_range(0, 255)));
        end else begin
          push_beat(tick_beat($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
        end
      end
      wait_idle();
      no_gaps = 1'b0;
    end
  endtask

  // With the largest timeouts a run of ticks must leave both commanded duties in place.
  task automatic test_long_timeout();
    apply_settings(500, 65535, 300, 1'b0, 1'b0);
    no_gaps = 1'b1;
    push_beat(frame_beat(11'd500, 8'hE0, 8'h12));
    push_beat(frame_beat(11'd501, 8'h60, 8'hC4));
    repeat (20) push_beat(tick_beat($urandom_range(0, 1), $urandom_range(0, 1)));
    apply_settings(500, 65534, 300, 1'b0, 1'b0);
    push_beat(tick_beat(1'b0, 1'b0));
    wait_idle();
    no_gaps = 1'b0;
  endtask

  // Result sink: random stalls, plus a long hold whenever a test asks for one.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      sink_hold = hold_req;
      hold_req  = 0;
    end
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold--;
    end else if (sink_gap > 0) begin
      out_tready <= 1'b0;
      sink_gap--;
    end else begin
      out_tready <= 1'b1;
      sink_gap = no_gaps ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_duties.size() == 0) begin
        report_mismatch("result beat with nothing pending, duty_a",
                        $signed(out_tdata[DUTY_W-1:0]), 0);
      end else begin
        want_duty = pending_duties.pop_front();
        if (out_tdata[DUTY_W-1:0] !== want_duty.duty_a)
          report_mismatch("duty_a", $signed(out_tdata[DUTY_W-1:0]), want_duty.duty_a);
        if (out_tdata[2*DUTY_W-1:DUTY_W] !== want_duty.duty_b)
          report_mismatch("duty_b", $signed(out_tdata[2*DUTY_W-1:DUTY_W]),
                          want_duty.duty_b);
      end
    end
  end

  initial begin
    m_base    = BASE_ID_RST;
    m_timeout = TIMEOUT_RST;
    m_test    = DBG_DUTY_RST;
    m_dbg_a   = 1'b0;
    m_dbg_b   = 1'b0;
    m_duty_a  = '0;
    m_duty_b  = '0;
    m_sil_a   = '0;
    m_sil_b   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_values();
    test_cmd_decode();
    test_timeout();
    test_debug_buttons();
    test_top_base_id();
    test_backpressure();
    test_random_traffic();
    test_long_timeout();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TIMEOUT: stream did not drain");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
